[rtl/cpcb_pkg.sv]
// Shared types and constants for the core performance counter bank.
`timescale 1ns / 1ps
`default_nettype none
package cpcb_pkg;

   localparam int COUNT_WIDTH = 64;
   localparam int NUM_CTRS    = 36;
   localparam int QUEUE_DEPTH = 2;
   localparam int DATA_WIDTH  = 64;
   localparam int AMT_WIDTH   = 32;
   localparam int SEL_WIDTH   = 6;

   localparam logic [3:0] EV_RETIRE   = 4'd0;
   localparam logic [3:0] EV_CYCLE    = 4'd1;
   localparam logic [3:0] EV_IC_ACC   = 4'd2;
   localparam logic [3:0] EV_IC_HIT   = 4'd3;
   localparam logic [3:0] EV_IC_MISS  = 4'd4;
   localparam logic [3:0] EV_DCACHE   = 4'd5;
   localparam logic [3:0] EV_FETCH    = 4'd6;
   localparam logic [3:0] EV_FWAIT    = 4'd7;
   localparam logic [3:0] EV_FIDLE    = 4'd8;
   localparam logic [3:0] EV_SQUASH   = 4'd9;
   localparam logic [3:0] EV_LOAD     = 4'd10;
   localparam logic [3:0] EV_STORE    = 4'd11;
   localparam logic [3:0] EV_LD_LAT   = 4'd12;
   localparam logic [3:0] EV_ST_LAT   = 4'd13;
   localparam logic [3:0] EV_READ     = 4'd14;

   localparam logic [6:0] OPC_MASK_NONE = 7'h00;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_LUI    = 7'h37;

   localparam logic [31:0] PC_STEP = 32'd4;

   localparam logic [0:0] REG_COUNT_ENABLE = 1'b0;

   localparam int C_RET        = 0;
   localparam int C_LOAD       = 1;
   localparam int C_STORE      = 2;
   localparam int C_BR         = 3;
   localparam int C_BR_TAKEN   = 4;
   localparam int C_JUMP       = 5;
   localparam int C_CSR        = 6;
   localparam int C_SYS        = 7;
   localparam int C_ALU        = 8;
   localparam int C_OTHER      = 9;
   localparam int C_PCYC       = 10;
   localparam int C_RESET      = 11;
   localparam int C_RETCYC     = 12;
   localparam int C_NR_LSU     = 13;
   localparam int C_NR_EMPTY   = 14;
   localparam int C_NR_OTHER   = 15;
   localparam int C_MEMISS     = 16;
   localparam int C_REDIR      = 17;
   localparam int C_CTL_MP     = 18;
   localparam int C_COND_MP    = 19;
   localparam int C_IC_ACC     = 20;
   localparam int C_IC_HIT     = 21;
   localparam int C_IC_MISS    = 22;
   localparam int C_IC_HITCYC  = 23;
   localparam int C_IC_MISSCYC = 24;
   localparam int C_DC_ACC     = 25;
   localparam int C_DC_CACHE   = 26;
   localparam int C_DC_HIT     = 27;
   localparam int C_FETCH      = 28;
   localparam int C_FWAIT      = 29;
   localparam int C_FIDLE      = 30;
   localparam int C_SQUASH     = 31;
   localparam int C_LD         = 32;
   localparam int C_ST         = 33;
   localparam int C_LDLAT      = 34;
   localparam int C_STLAT      = 35;

   typedef struct packed {
      logic [NUM_CTRS-1:0]  one_mask;
      logic [NUM_CTRS-1:0]  amt_mask;
      logic [AMT_WIDTH-1:0] amount;
      logic                 is_read;
      logic [SEL_WIDTH-1:0] sel;
   } entry_type;

endpackage
`default_nettype wire

[rtl/cpcb_queue.sv]
// Small first-in first-out queue built from registers.
`timescale 1ns / 1ps
`default_nettype none
module cpcb_queue #(
   parameter int WIDTH = cpcb_pkg::DATA_WIDTH,
   parameter int DEPTH = cpcb_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         data_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

[rtl/cpcb_front.sv]
// Front end: enable register, event decode and counter update masks.
`timescale 1ns / 1ps
`default_nettype none
module cpcb_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [2:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready,
   input  wire logic [3:0]            req_type,
   input  wire logic [31:0]           req_retire_pc,
   input  wire logic [31:0]           req_retire_next_pc,
   input  wire logic [31:0]           req_retire_word,
   input  wire logic [10:0]           req_cycle_flags,
   input  wire logic [31:0]           req_amount,
   input  wire logic                  req_dcache_hit,
   input  wire logic                  req_dcache_cacheable,
   input  wire logic [5:0]            req_counter_select,
   output cpcb_pkg::entry_type        entry
);

   logic count_enable_ff, count_enable_in;
   logic reg_hit;
   logic [cpcb_pkg::NUM_CTRS-1:0] one_mask, amt_mask;
   logic [6:0] opcode;
   logic [2:0] funct3;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == cpcb_pkg::REG_COUNT_ENABLE);
   assign prdata  = reg_hit ? {31'd0, count_enable_ff} : 32'd0;

   always_comb begin
      count_enable_in = count_enable_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         count_enable_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_enable_ff <= 1'b0;
      end else begin
         count_enable_ff <= count_enable_in;
      end
   end

   assign opcode = req_retire_word[6:0];
   assign funct3 = req_retire_word[14:12];

   always_comb begin
      one_mask = '0;
      amt_mask = '0;
      unique case (req_type)
         cpcb_pkg::EV_RETIRE: begin
            one_mask[cpcb_pkg::C_RET] = 1'b1;
            unique case (opcode)
               cpcb_pkg::OPC_LOAD:  one_mask[cpcb_pkg::C_LOAD] = 1'b1;
               cpcb_pkg::OPC_STORE: one_mask[cpcb_pkg::C_STORE] = 1'b1;
               cpcb_pkg::OPC_BRANCH: begin
                  one_mask[cpcb_pkg::C_BR] = 1'b1;
                  one_mask[cpcb_pkg::C_BR_TAKEN] =
                     (req_retire_next_pc != req_retire_pc + cpcb_pkg::PC_STEP);
               end
               cpcb_pkg::OPC_JAL, cpcb_pkg::OPC_JALR: begin
                  one_mask[cpcb_pkg::C_JUMP] = 1'b1;
               end
               cpcb_pkg::OPC_SYSTEM: begin
                  if (funct3 != 3'd0) begin
                     one_mask[cpcb_pkg::C_CSR] = 1'b1;
                  end else begin
                     one_mask[cpcb_pkg::C_SYS] = 1'b1;
                  end
               end
               cpcb_pkg::OPC_OP_IMM, cpcb_pkg::OPC_AUIPC,
               cpcb_pkg::OPC_OP, cpcb_pkg::OPC_LUI: begin
                  one_mask[cpcb_pkg::C_ALU] = 1'b1;
               end
               default: one_mask[cpcb_pkg::C_OTHER] = 1'b1;
            endcase
         end
         cpcb_pkg::EV_CYCLE: begin
            one_mask[cpcb_pkg::C_PCYC]    = 1'b1;
            one_mask[cpcb_pkg::C_MEMISS]  = req_cycle_flags[6];
            one_mask[cpcb_pkg::C_REDIR]   = req_cycle_flags[7];
            one_mask[cpcb_pkg::C_CTL_MP]  = req_cycle_flags[9];
            one_mask[cpcb_pkg::C_COND_MP] = req_cycle_flags[10];
            priority if (req_cycle_flags[8]) begin
               one_mask[cpcb_pkg::C_RESET] = 1'b1;
            end else if (req_cycle_flags[5]) begin
               one_mask[cpcb_pkg::C_RETCYC] = 1'b1;
            end else if (req_cycle_flags[0]) begin
               one_mask[cpcb_pkg::C_NR_LSU] = 1'b1;
            end else if (req_cycle_flags[4:1] == 4'd0) begin
               one_mask[cpcb_pkg::C_NR_EMPTY] = 1'b1;
            end else begin
               one_mask[cpcb_pkg::C_NR_OTHER] = 1'b1;
            end
         end
         cpcb_pkg::EV_IC_ACC: one_mask[cpcb_pkg::C_IC_ACC] = 1'b1;
         cpcb_pkg::EV_IC_HIT: begin
            one_mask[cpcb_pkg::C_IC_HIT]    = 1'b1;
            amt_mask[cpcb_pkg::C_IC_HITCYC] = 1'b1;
         end
         cpcb_pkg::EV_IC_MISS: begin
            one_mask[cpcb_pkg::C_IC_MISS]    = 1'b1;
            amt_mask[cpcb_pkg::C_IC_MISSCYC] = 1'b1;
         end
         cpcb_pkg::EV_DCACHE: begin
            one_mask[cpcb_pkg::C_DC_ACC]   = 1'b1;
            one_mask[cpcb_pkg::C_DC_CACHE] = req_dcache_cacheable;
            one_mask[cpcb_pkg::C_DC_HIT]   = req_dcache_hit;
         end
         cpcb_pkg::EV_FETCH:  one_mask[cpcb_pkg::C_FETCH] = 1'b1;
         cpcb_pkg::EV_FWAIT:  one_mask[cpcb_pkg::C_FWAIT] = 1'b1;
         cpcb_pkg::EV_FIDLE:  one_mask[cpcb_pkg::C_FIDLE] = 1'b1;
         cpcb_pkg::EV_SQUASH: amt_mask[cpcb_pkg::C_SQUASH] = 1'b1;
         cpcb_pkg::EV_LOAD:   one_mask[cpcb_pkg::C_LD] = 1'b1;
         cpcb_pkg::EV_STORE:  one_mask[cpcb_pkg::C_ST] = 1'b1;
         cpcb_pkg::EV_LD_LAT: amt_mask[cpcb_pkg::C_LDLAT] = 1'b1;
         cpcb_pkg::EV_ST_LAT: amt_mask[cpcb_pkg::C_STLAT] = 1'b1;
         default: begin
         end
      endcase
      if (req_type != cpcb_pkg::EV_RETIRE && !count_enable_ff) begin
         one_mask = '0;
         amt_mask = '0;
      end
   end

   always_comb begin
      entry.one_mask = one_mask;
      entry.amt_mask = amt_mask;
      entry.amount   = req_amount;
      entry.is_read  = (req_type == cpcb_pkg::EV_READ);
      entry.sel      = req_counter_select;
   end

endmodule
`default_nettype wire

[rtl/cpcb_back.sv]
// Back end: the counter registers, their update and the read-out path.
`timescale 1ns / 1ps
`default_nettype none
module cpcb_back #(
   parameter int COUNT_WIDTH = cpcb_pkg::COUNT_WIDTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             entry_valid,
   input  wire cpcb_pkg::entry_type              entry,
   output logic                                  entry_take,
   input  wire logic                             out_full,
   output logic                                  out_push,
   output logic      [cpcb_pkg::DATA_WIDTH-1:0]  out_data
);

   logic [COUNT_WIDTH-1:0] ctr_ff [cpcb_pkg::NUM_CTRS];
   logic [COUNT_WIDTH-1:0] ctr_in [cpcb_pkg::NUM_CTRS];
   logic [COUNT_WIDTH-1:0] amount_w;

   assign entry_take = entry_valid && (!entry.is_read || !out_full);
   assign out_push   = entry_take && entry.is_read;
   assign amount_w   = COUNT_WIDTH'(entry.amount);

   always_comb begin
      for (int i = 0; i < cpcb_pkg::NUM_CTRS; i++) begin
         ctr_in[i] = ctr_ff[i];
         if (entry_take && entry.one_mask[i]) begin
            ctr_in[i] = ctr_ff[i] + 1'b1;
         end else if (entry_take && entry.amt_mask[i]) begin
            ctr_in[i] = ctr_ff[i] + amount_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cpcb_pkg::NUM_CTRS; i++) begin
            ctr_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < cpcb_pkg::NUM_CTRS; i++) begin
            ctr_ff[i] <= ctr_in[i];
         end
      end
   end

   always_comb begin
      out_data = '0;
      if (entry.sel < cpcb_pkg::SEL_WIDTH'(cpcb_pkg::NUM_CTRS)) begin
         out_data[COUNT_WIDTH-1:0] = ctr_ff[entry.sel];
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(out_push && out_full))
      else $error("Read result pushed into a full output queue.");

   a_push_only_for_read: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (entry_valid && entry.is_read))
      else $error("Result produced for an event that is not a read.");

   a_retired_steps_by_one: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (ctr_ff[cpcb_pkg::C_RET] == $past(ctr_ff[cpcb_pkg::C_RET]) ||
                         ctr_ff[cpcb_pkg::C_RET] == $past(ctr_ff[cpcb_pkg::C_RET]) + 1'b1))
      else $error("Retired instruction counter moved by more than one.");

endmodule
`default_nettype wire

[rtl/core_performance_counter_bank_unit.sv]
// Top level of the core performance counter bank.
// Throughput: one event beat per cycle, sustained, while results are taken.
// A read beat accepted into the event queue shows its result on the rsp ports once the result
// is written into the result queue; the event queue and the result queue each add one register.
// Reset clears all counters, the count enable register and both queues.
`timescale 1ns / 1ps
`default_nettype none
module core_performance_counter_bank_unit #(
   parameter int COUNT_WIDTH = cpcb_pkg::COUNT_WIDTH,
   parameter int QUEUE_DEPTH = cpcb_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   input  wire logic        push,
   output logic             full,
   input  wire logic [3:0]  req_type,
   input  wire logic [31:0] req_retire_pc,
   input  wire logic [31:0] req_retire_next_pc,
   input  wire logic [31:0] req_retire_word,
   input  wire logic [10:0] req_cycle_flags,
   input  wire logic [31:0] req_amount,
   input  wire logic        req_dcache_hit,
   input  wire logic        req_dcache_cacheable,
   input  wire logic [5:0]  req_counter_select,
   output logic             empty,
   input  wire logic        pop,
   output logic [63:0]      rsp_read_data
);

   cpcb_pkg::entry_type front_entry, back_entry;
   logic [$bits(cpcb_pkg::entry_type)-1:0] back_bits;
   logic evq_empty, back_take;
   logic out_full, out_push;
   logic [cpcb_pkg::DATA_WIDTH-1:0] out_data;

   cpcb_front u_front (
      .clock                (clock),
      .reset                (reset),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready),
      .req_type             (req_type),
      .req_retire_pc        (req_retire_pc),
      .req_retire_next_pc   (req_retire_next_pc),
      .req_retire_word      (req_retire_word),
      .req_cycle_flags      (req_cycle_flags),
      .req_amount           (req_amount),
      .req_dcache_hit       (req_dcache_hit),
      .req_dcache_cacheable (req_dcache_cacheable),
      .req_counter_select   (req_counter_select),
      .entry                (front_entry)
   );

   cpcb_queue #(
      .WIDTH ($bits(cpcb_pkg::entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_event_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (front_entry),
      .rd_en   (back_take),
      .rd_data (back_bits),
      .full    (full),
      .empty   (evq_empty)
   );

   assign back_entry = cpcb_pkg::entry_type'(back_bits);

   cpcb_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (!evq_empty),
      .entry       (back_entry),
      .entry_take  (back_take),
      .out_full    (out_full),
      .out_push    (out_push),
      .out_data    (out_data)
   );

   cpcb_queue #(
      .WIDTH (cpcb_pkg::DATA_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (out_data),
      .rd_en   (pop),
      .rd_data (rsp_read_data),
      .full    (out_full),
      .empty   (empty)
   );

endmodule
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the core performance counter bank unit.
`timescale 1ns / 1ps
module tb;

   localparam int          CYCLE_LIMIT      = 200000;
   localparam int          DRAIN_CYCLES     = 8;
   localparam int          RX_HOLD_CYCLES   = 300;
   localparam logic [3:0]  EV_UNUSED        = 4'd15;
   localparam logic [2:0]  ADDR_COUNT_ENABLE = {cpcb_pkg::REG_COUNT_ENABLE, 2'b00};
   localparam logic [2:0]  ADDR_UNMAPPED    = 3'd4;

   typedef struct {
      logic [3:0]  kind;
      logic [31:0] pc;
      logic [31:0] next_pc;
      logic [31:0] word;
      logic [10:0] flags;
      logic [31:0] amount;
      logic        hit;
      logic        cacheable;
      logic [5:0]  sel;
   } perf_event_type;

   logic        clock                = 1'b0;
   logic        reset                = 1'b1;
   logic        psel                 = 1'b0;
   logic        penable              = 1'b0;
   logic        pwrite               = 1'b0;
   logic [2:0]  paddr                = '0;
   logic [31:0] pwdata               = '0;
   logic [31:0] prdata;
   logic        pready;
   logic        push                 = 1'b0;
   logic        full;
   logic [3:0]  req_type             = '0;
   logic [31:0] req_retire_pc        = '0;
   logic [31:0] req_retire_next_pc   = '0;
   logic [31:0] req_retire_word      = '0;
   logic [10:0] req_cycle_flags      = '0;
   logic [31:0] req_amount           = '0;
   logic        req_dcache_hit       = 1'b0;
   logic        req_dcache_cacheable = 1'b0;
   logic [5:0]  req_counter_select   = '0;
   logic        empty;
   logic        pop                  = 1'b0;
   logic [63:0] rsp_read_data;

   perf_event_type                   event_backlog[$];
   perf_event_type                   offered_event;
   logic [63:0]                      read_values_due[$];
   logic [cpcb_pkg::COUNT_WIDTH-1:0] counter_shadow[cpcb_pkg::NUM_CTRS];
   logic                             count_enable_shadow = 1'b0;
   int                               mismatch_count = 0;
   int                               cycle_count = 0;
   int                               send_idle_pct = 0;
   int                               pop_stall_pct = 0;
   int                               rx_hold_left = 0;
   logic                             rx_hold_go = 1'b0;

   core_performance_counter_bank_unit dut (
      .clock                (clock),
      .reset                (reset),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready),
      .push                 (push),
      .full                 (full),
      .req_type             (req_type),
      .req_retire_pc        (req_retire_pc),
      .req_retire_next_pc   (req_retire_next_pc),
      .req_retire_word      (req_retire_word),
      .req_cycle_flags      (req_cycle_flags),
      .req_amount           (req_amount),
      .req_dcache_hit       (req_dcache_hit),
      .req_dcache_cacheable (req_dcache_cacheable),
      .req_counter_select   (req_counter_select),
      .empty                (empty),
      .pop                  (pop),
      .rsp_read_data        (rsp_read_data)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] expected,
                                  input logic [63:0] actual);
      $display("MISMATCH %s: expected %h, got %h", what, expected, actual);
      mismatch_count++;
   endtask

   task automatic bump_counter(input int idx, input logic [63:0] by);
      counter_shadow[idx] = counter_shadow[idx] + cpcb_pkg::COUNT_WIDTH'(by);
   endtask

   task automatic count_retire(input perf_event_type ev);
      bump_counter(cpcb_pkg::C_RET, 64'd1);
      case (ev.word[6:0])
         cpcb_pkg::OPC_LOAD:   bump_counter(cpcb_pkg::C_LOAD, 64'd1);
         cpcb_pkg::OPC_STORE:  bump_counter(cpcb_pkg::C_STORE, 64'd1);
         cpcb_pkg::OPC_BRANCH: begin
            bump_counter(cpcb_pkg::C_BR, 64'd1);
            if (ev.next_pc != ev.pc + cpcb_pkg::PC_STEP)
               bump_counter(cpcb_pkg::C_BR_TAKEN, 64'd1);
         end
         cpcb_pkg::OPC_JAL, cpcb_pkg::OPC_JALR: bump_counter(cpcb_pkg::C_JUMP, 64'd1);
         cpcb_pkg::OPC_SYSTEM: begin
            if (ev.word[14:12] != 3'd0) bump_counter(cpcb_pkg::C_CSR, 64'd1);
            else bump_counter(cpcb_pkg::C_SYS, 64'd1);
         end
         cpcb_pkg::OPC_OP_IMM, cpcb_pkg::OPC_AUIPC, cpcb_pkg::OPC_OP, cpcb_pkg::OPC_LUI:
            bump_counter(cpcb_pkg::C_ALU, 64'd1);
         default: bump_counter(cpcb_pkg::C_OTHER, 64'd1);
      endcase
   endtask

   task automatic count_cycle(input logic [10:0] f);
      bump_counter(cpcb_pkg::C_PCYC, 64'd1);
      if (f[6]) bump_counter(cpcb_pkg::C_MEMISS, 64'd1);
      if (f[7]) bump_counter(cpcb_pkg::C_REDIR, 64'd1);
      if (f[9]) bump_counter(cpcb_pkg::C_CTL_MP, 64'd1);
      if (f[10]) bump_counter(cpcb_pkg::C_COND_MP, 64'd1);
      if (f[8]) bump_counter(cpcb_pkg::C_RESET, 64'd1);
      else if (f[5]) bump_counter(cpcb_pkg::C_RETCYC, 64'd1);
      else if (f[0]) bump_counter(cpcb_pkg::C_NR_LSU, 64'd1);
      else if (f[4:1] == 4'd0) bump_counter(cpcb_pkg::C_NR_EMPTY, 64'd1);
      else bump_counter(cpcb_pkg::C_NR_OTHER, 64'd1);
   endtask

   task automatic count_event(input perf_event_type ev);
      if (ev.kind == cpcb_pkg::EV_RETIRE) begin
         count_retire(ev);
      end else if (ev.kind == cpcb_pkg::EV_READ) begin
         read_values_due.push_back((ev.sel < cpcb_pkg::NUM_CTRS) ?
                                   64'(counter_shadow[ev.sel]) : 64'd0);
      end else if (count_enable_shadow) begin
         case (ev.kind)
            cpcb_pkg::EV_CYCLE:   count_cycle(ev.flags);
            cpcb_pkg::EV_IC_ACC:  bump_counter(cpcb_pkg::C_IC_ACC, 64'd1);
            cpcb_pkg::EV_IC_HIT: begin
               bump_counter(cpcb_pkg::C_IC_HIT, 64'd1);
               bump_counter(cpcb_pkg::C_IC_HITCYC, 64'(ev.amount));
            end
            cpcb_pkg::EV_IC_MISS: begin
               bump_counter(cpcb_pkg::C_IC_MISS, 64'd1);
               bump_counter(cpcb_pkg::C_IC_MISSCYC, 64'(ev.amount));
            end
            cpcb_pkg::EV_DCACHE: begin
               bump_counter(cpcb_pkg::C_DC_ACC, 64'd1);
               bump_counter(cpcb_pkg::C_DC_CACHE, 64'(ev.cacheable));
               bump_counter(cpcb_pkg::C_DC_HIT, 64'(ev.hit));
            end
            cpcb_pkg::EV_FETCH:   bump_counter(cpcb_pkg::C_FETCH, 64'd1);
            cpcb_pkg::EV_FWAIT:   bump_counter(cpcb_pkg::C_FWAIT, 64'd1);
            cpcb_pkg::EV_FIDLE:   bump_counter(cpcb_pkg::C_FIDLE, 64'd1);
            cpcb_pkg::EV_SQUASH:  bump_counter(cpcb_pkg::C_SQUASH, 64'(ev.amount));
            cpcb_pkg::EV_LOAD:    bump_counter(cpcb_pkg::C_LD, 64'd1);
            cpcb_pkg::EV_STORE:   bump_counter(cpcb_pkg::C_ST, 64'd1);
            cpcb_pkg::EV_LD_LAT:  bump_counter(cpcb_pkg::C_LDLAT, 64'(ev.amount));
            cpcb_pkg::EV_ST_LAT:  bump_counter(cpcb_pkg::C_STLAT, 64'(ev.amount));
            default: ;
         endcase
      end
   endtask

   function automatic perf_event_type flag_event(input logic [3:0] kind,
                                                 input logic [10:0] flags,
                                                 input logic [31:0] amount);
      perf_event_type ev;
      ev.kind      = kind;
      ev.pc        = $urandom;
      ev.next_pc   = $urandom;
      ev.word      = $urandom;
      ev.flags     = flags;
      ev.amount    = amount;
      ev.hit       = 1'($urandom_range(0, 1));
      ev.cacheable = 1'($urandom_range(0, 1));
      ev.sel       = 6'($urandom_range(0, 63));
      return ev;
   endfunction

   function automatic perf_event_type retire_event(input logic [6:0] opc,
                                                   input logic [2:0] funct3,
                                                   input logic [31:0] pc,
                                                   input logic [31:0] npc);
      perf_event_type ev;
      ev              = flag_event(cpcb_pkg::EV_RETIRE, 11'($urandom), $urandom);
      ev.word[6:0]    = opc;
      ev.word[14:12]  = funct3;
      ev.pc           = pc;
      ev.next_pc      = npc;
      return ev;
   endfunction

   function automatic perf_event_type read_event(input logic [5:0] sel);
      perf_event_type ev;
      ev     = flag_event(cpcb_pkg::EV_READ, 11'($urandom), $urandom);
      ev.sel = sel;
      return ev;
   endfunction

   function automatic perf_event_type random_event(input int read_pct);
      perf_event_type ev;
      int             pick;
      logic [6:0]     opc;
      logic [31:0]    pc;
      logic [10:0]    f;
      logic [31:0]    amt;
      pick = $urandom_range(0, 99);
      f = 11'($urandom);
      if ($urandom_range(0, 1)) f[8] = 1'b0;
      if ($urandom_range(0, 1)) f[5] = 1'b0;
      if ($urandom_range(0, 1)) f[0] = 1'b0;
      if ($urandom_range(0, 2) == 0) f[4:1] = 4'd0;
      case ($urandom_range(0, 9))
         0: amt = 32'd0;
         1: amt = 32'hFFFF_FFFF;
         default: amt = $urandom;
      endcase
      if (pick < read_pct) begin
         ev = read_event(($urandom_range(0, 9) == 0) ?
                         6'($urandom_range(cpcb_pkg::NUM_CTRS, 63)) :
                         6'($urandom_range(0, cpcb_pkg::NUM_CTRS - 1)));
      end else if (pick < read_pct + 25) begin
         case ($urandom_range(0, 11))
            0: opc = cpcb_pkg::OPC_LOAD;
            1: opc = cpcb_pkg::OPC_STORE;
            2: opc = cpcb_pkg::OPC_BRANCH;
            3: opc = cpcb_pkg::OPC_JAL;
            4: opc = cpcb_pkg::OPC_JALR;
            5: opc = cpcb_pkg::OPC_SYSTEM;
            6: opc = cpcb_pkg::OPC_OP_IMM;
            7: opc = cpcb_pkg::OPC_AUIPC;
            8: opc = cpcb_pkg::OPC_OP;
            9: opc = cpcb_pkg::OPC_LUI;
            10: opc = cpcb_pkg::OPC_BRANCH;
            default: opc = 7'($urandom);
         endcase
         pc = $urandom;
         ev = retire_event(opc, ($urandom_range(0, 1) != 0) ? 3'd0 : 3'($urandom), pc,
                           ($urandom_range(0, 1) != 0) ? pc + cpcb_pkg::PC_STEP : $urandom);
      end else if (pick < read_pct + 27) begin
         ev = flag_event(EV_UNUSED, f, amt);
      end else begin
         ev = flag_event(4'($urandom_range(1, 13)), f, amt);
      end
      return ev;
   endfunction

   task automatic add_random_events(input int count, input int read_pct);
      perf_event_type ev;
      int             added;
      added = 0;
      while (added < count) begin
         ev = random_event(read_pct);
         event_backlog.push_back(ev);
         if (ev.kind != EV_UNUSED) added++;
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (event_backlog.size() != 0 || push || read_values_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      if (addr == ADDR_COUNT_ENABLE) count_enable_shadow = data[0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_check_enable();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_COUNT_ENABLE;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      if (prdata !== {31'd0, count_enable_shadow})
         report_mismatch("count_enable readback", {63'd0, count_enable_shadow}, 64'(prdata));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
      send_idle_pct = tx_pct;
      pop_stall_pct = rx_pct;
      add_random_events(count, 25);
      wait_idle();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            count_event(offered_event);
            void'(event_backlog.pop_front());
         end
         if (!(push && full)) begin
            if (event_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered_event = event_backlog[0];
               push                 <= 1'b1;
               req_type             <= offered_event.kind;
               req_retire_pc        <= offered_event.pc;
               req_retire_next_pc   <= offered_event.next_pc;
               req_retire_word      <= offered_event.word;
               req_cycle_flags      <= offered_event.flags;
               req_amount           <= offered_event.amount;
               req_dcache_hit       <= offered_event.hit;
               req_dcache_cacheable <= offered_event.cacheable;
               req_counter_select   <= offered_event.sel;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (rx_hold_go) rx_hold_left <= RX_HOLD_CYCLES;
      else if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
   end

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (read_values_due.size() == 0)
               report_mismatch("read beat with nothing due", 64'd0, rsp_read_data);
            else if (rsp_read_data !== read_values_due[0])
               report_mismatch("read_data", read_values_due[0], rsp_read_data);
            if (read_values_due.size() != 0) void'(read_values_due.pop_front());
         end
         pop <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= pop_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("core_performance_counter_bank_unit test failed");
         $finish;
      end
   end

   initial begin
      perf_event_type ev;
      for (int i = 0; i < cpcb_pkg::NUM_CTRS; i++) counter_shadow[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      csr_check_enable();
      csr_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
      csr_check_enable();
      event_backlog.push_back(flag_event(cpcb_pkg::EV_CYCLE, 11'h7FF, 32'd0));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_IC_HIT, 11'h000, 32'hFFFF_FFFF));
      event_backlog.push_back(read_event(6'(cpcb_pkg::C_PCYC)));
      wait_idle();

      csr_write(ADDR_COUNT_ENABLE, 32'hFFFF_FFFF);
      csr_check_enable();
      event_backlog.push_back(retire_event(cpcb_pkg::OPC_LOAD, 3'd2,
                                           32'h0000_1000, 32'h0000_1004));
      event_backlog.push_back(retire_event(cpcb_pkg::OPC_STORE, 3'd2,
                                           32'h0000_1004, 32'h0000_1008));
      event_backlog.push_back(retire_event(cpcb_pkg::OPC_BRANCH, 3'd0,
                                           32'h0000_1008, 32'h0000_2000));
      event_backlog.push_back(retire_event(cpcb_pkg::OPC_BRANCH, 3'd1,
                                           32'hFFFF_FFFC, 32'h0000_0000));
      event_backlog.push_back(retire_event(cpcb_pkg::OPC_JALR, 3'd0,
                                           32'h0000_2000, 32'h0000_0040));
      event_backlog.push_back(retire_event(cpcb_pkg::OPC_SYSTEM, 3'd1,
                                           32'h0000_0040, 32'h0000_0044));
      event_backlog.push_back(retire_event(cpcb_pkg::OPC_SYSTEM, 3'd0,
                                           32'h0000_0044, 32'h0000_0100));
      event_backlog.push_back(retire_event(cpcb_pkg::OPC_MASK_NONE, 3'd7,
                                           32'h0000_0100, 32'h0000_0104));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_CYCLE, 11'h7FF, 32'd0));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_CYCLE, 11'h020, 32'd0));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_CYCLE, 11'h001, 32'd0));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_CYCLE, 11'h000, 32'd0));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_CYCLE, 11'h01E, 32'd0));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_IC_ACC, 11'h000, 32'd0));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_IC_MISS, 11'h000, 32'hFFFF_FFFF));
      ev = flag_event(cpcb_pkg::EV_DCACHE, 11'h000, 32'd0);
      ev.hit = 1'b1;
      ev.cacheable = 1'b1;
      event_backlog.push_back(ev);
      event_backlog.push_back(flag_event(cpcb_pkg::EV_FETCH, 11'h000, 32'd0));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_FWAIT, 11'h000, 32'd0));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_FIDLE, 11'h000, 32'd0));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_SQUASH, 11'h000, 32'hFFFF_FFFF));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_LOAD, 11'h000, 32'd0));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_STORE, 11'h000, 32'd0));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_LD_LAT, 11'h000, 32'hFFFF_FFFF));
      event_backlog.push_back(flag_event(cpcb_pkg::EV_ST_LAT, 11'h000, 32'd0));
      event_backlog.push_back(flag_event(EV_UNUSED, 11'h7FF, 32'hFFFF_FFFF));
      event_backlog.push_back(read_event(6'd63));
      wait_idle();

      run_phase(0, 0, 320);

      csr_write(ADDR_COUNT_ENABLE, 32'hFFFF_FFFE);
      csr_check_enable();
      run_phase(71, 0, 200);

      csr_write(ADDR_COUNT_ENABLE, 32'h0000_0001);
      csr_check_enable();
      run_phase(0, 71, 320);

      send_idle_pct = 0;
      pop_stall_pct = 0;
      @(posedge clock);
      rx_hold_go <= 1'b1;
      @(posedge clock);
      rx_hold_go <= 1'b0;
      add_random_events(60, 70);
      wait_idle();

      csr_write(ADDR_COUNT_ENABLE, 32'h8000_0001);
      csr_check_enable();
      run_phase(6, 6, 350);

      pop_stall_pct = 0;
      wait_idle();
      if (mismatch_count == 0) begin
         $display("core_performance_counter_bank_unit test passed");
      end else begin
         $display("core_performance_counter_bank_unit test failed");
      end
      $finish;
   end

endmodule
